// ===== src/mrrt_pkg.sv =====
// ============================================================================
// mrrt_pkg - shared types and constants of the RPM ramp throttle
// Transfer structs, action and register codes, reset values and sizes.
// ============================================================================
package mrrt_pkg;

    localparam int ENGINES    = 8;
    localparam int ENG_AW     = (ENGINES > 1) ? $clog2(ENGINES) : 1;
    localparam int IDX_W      = 4;
    localparam int CH_W       = 3;
    localparam int RPM_W      = 16;
    localparam int CODE_W     = 24;
    localparam int FAULT_W    = 4;
    localparam int KA_W       = 8;
    localparam int GAIN_W     = 8;
    localparam int TGT_W      = RPM_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        ACT_SET_THROTTLE = 2'd0,
        ACT_TICK         = 2'd1,
        ACT_ENABLE_RUN   = 2'd2,
        ACT_SERVICE      = 2'd3
    } act_t;

    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_UP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DOWN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KA_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAC_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DAC_OFFSET = 3'd4;

    localparam int FLT_GENERAL     = 0;
    localparam int FLT_DEVICE      = 1;
    localparam int FLT_BAD_INDEX   = 2;
    localparam int FLT_NOT_RUNNING = 3;

    localparam logic [FAULT_W-1:0] FAULT_RESET = 4'b1000;

    localparam logic [RPM_W-1:0]  RST_RAMP_UP    = 16'd200;
    localparam logic [RPM_W-1:0]  RST_RAMP_DOWN  = 16'd20;
    localparam logic [KA_W-1:0]   RST_KA_LIMIT   = 8'd30;
    localparam logic [GAIN_W-1:0] RST_DAC_GAIN   = 8'd40;
    localparam logic [RPM_W-1:0]  RST_DAC_OFFSET = 16'd10925;
    localparam logic [KA_W-1:0]   KA_MAX         = 8'hFF;

    typedef struct packed {
        act_t             action;
        logic [IDX_W-1:0] engine_index;
        logic [RPM_W-1:0] target_rpm;
        logic             ramp_mode;
        logic             device_fault;
    } in_t;

    typedef struct packed {
        logic               write_valid;
        logic [CH_W-1:0]    dac_channel;
        logic [CODE_W-1:0]  dac_code;
        logic [FAULT_W-1:0] fault_flags;
        logic               running;
        logic               last;
    } out_t;

    typedef struct packed {
        logic [RPM_W-1:0]  ramp_up_step;
        logic [RPM_W-1:0]  ramp_down_step;
        logic [KA_W-1:0]   keepalive_limit;
        logic [GAIN_W-1:0] dac_gain;
        logic [RPM_W-1:0]  dac_offset;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_UPDATE,
        ST_EMIT_WR,
        ST_EMIT_ZERO,
        ST_EMIT_NONE
    } state_t;

endpackage

// ===== src/mrrt_ram.sv =====
// ============================================================================
// mrrt_ram - generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ============================================================================
module mrrt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/mrrt_calc.sv =====
// ============================================================================
// mrrt_calc - ramp step and DAC code arithmetic
// Moves an RPM one slew step toward its target and scales an RPM to a code.
// ============================================================================
module mrrt_calc (
    input  mrrt_pkg::cfg_t                    cfg,
    input  logic [mrrt_pkg::RPM_W-1:0]        present,
    input  logic [mrrt_pkg::RPM_W-1:0]        target,
    input  logic [mrrt_pkg::RPM_W-1:0]        code_rpm,
    output logic [mrrt_pkg::RPM_W-1:0]        ramped,
    output logic [mrrt_pkg::CODE_W-1:0]       code
);
    import mrrt_pkg::*;

    logic [RPM_W:0]      up_sum;
    logic [RPM_W-1:0]    up_sat;
    logic [RPM_W-1:0]    down_val;
    logic [CODE_W-1:0]   product;
    logic [CODE_W:0]     code_sum;

    // Slew step: saturate at full scale and never pass the target.
    always_comb
    begin
        up_sum   = {1'b0, present} + {1'b0, cfg.ramp_up_step};
        up_sat   = up_sum[RPM_W] ? '1 : up_sum[RPM_W-1:0];
        down_val = (present >= cfg.ramp_down_step) ? present - cfg.ramp_down_step : '0;
        if (target > present)
        begin
            ramped = (up_sat > target) ? target : up_sat;
        end
        else
        begin
            ramped = (down_val < target) ? target : down_val;
        end
    end

    // Code is offset plus gain times RPM, clipped at the top of the range.
    always_comb
    begin
        product  = CODE_W'(cfg.dac_gain) * CODE_W'(code_rpm);
        code_sum = {1'b0, product} + (CODE_W + 1)'(cfg.dac_offset);
        code     = code_sum[CODE_W] ? '1 : code_sum[CODE_W-1:0];
    end

endmodule

// ===== src/multichannel_rpm_ramp_throttle_top.sv =====
// ============================================================================
// multichannel_rpm_ramp_throttle_top - per-engine throttle sequencer
// Stores per-engine targets, services the engines in scan order and emits DAC
// writes, with a command keepalive watchdog that zeroes every channel.
// ============================================================================
//
//  Channel   Signals                        Direction  Transfer when
//  -------   -----------------------------  ---------  ---------------------
//  input     in_valid, in_ready, in_data    in         in_valid & in_ready
//  result    out_valid, out_ready, out_data out        out_valid & out_ready
//  config    cfg_we, cfg_index, cfg_data    in         cfg_we
//
//  An item that causes one result without a memory read is accepted and then
//  loads the result register. Setting all engines writes each target memory
//  entry in turn. A running service reads both memories, updates the scanned
//  engine and emits its results (up to nine) through the single output
//  register, which loads one result per cycle while the output is free.
//  Reset clears all control state and the per-entry valid bits of both
//  memories, so unwritten entries read as zero; no clearing pass is needed.
//  A stalled output only holds the sequencer in an emit state; an item
//  accepted meanwhile is worked on while the previous result waits.
//
// Per-engine state lives in two memories: targets with their ramp mode, and
// the present RPM. Only one item is in flight at a time, so a read never
// overlaps a write of the same entry and no forwarding is needed.
// ============================================================================
module multichannel_rpm_ramp_throttle_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  mrrt_pkg::in_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output mrrt_pkg::out_t                    out_data,
    input  logic                              cfg_we,
    input  logic [mrrt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mrrt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mrrt_pkg::*;

    localparam logic [ENG_AW-1:0] LAST_ENG = ENG_AW'(ENGINES - 1);

    state_t              state_reg,   state_next;
    logic                run_reg,     run_next;
    logic [ENG_AW-1:0]   scan_reg,    scan_next;
    logic [ENGINES-1:0]  tick_reg,    tick_next;
    logic [KA_W-1:0]     ka_cnt_reg,  ka_cnt_next;
    logic                ka_inh_reg,  ka_inh_next;
    logic [FAULT_W-1:0]  fault_reg,   fault_next;
    cfg_t                cfg_reg,     cfg_next;
    logic [ENGINES-1:0]  tgt_vld_reg, tgt_vld_next;
    logic [ENGINES-1:0]  cur_vld_reg, cur_vld_next;
    logic [ENG_AW-1:0]   cnt_reg,     cnt_next;
    logic [ENG_AW-1:0]   ch_reg,      ch_next;
    logic                tout_reg,    tout_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    out_t                out_data_reg;

    // Payload registers, no reset.
    logic [RPM_W-1:0]    item_rpm_reg,  item_rpm_next;
    logic                item_mode_reg, item_mode_next;
    logic [RPM_W-1:0]    p_reg,         p_next;

    // Memory ports.
    logic                tgt_we;
    logic [ENG_AW-1:0]   tgt_waddr;
    logic [TGT_W-1:0]    tgt_wdata;
    logic [TGT_W-1:0]    tgt_rdata;
    logic                cur_we;
    logic [RPM_W-1:0]    cur_rdata;

    // Service decode.
    logic [TGT_W-1:0]    tgt_word;
    logic [RPM_W-1:0]    tgt_rpm;
    logic                tgt_mode;
    logic [RPM_W-1:0]    cur_rpm;
    logic [RPM_W-1:0]    ramped;
    logic [RPM_W-1:0]    new_rpm;
    logic [CODE_W-1:0]   code;
    logic                wr_now;
    logic                tout_now;

    logic                out_free;
    logic                out_load;
    out_t                out_load_data;
    logic [FAULT_W-1:0]  svc_fault;

    mrrt_ram #(
        .WIDTH (TGT_W),
        .DEPTH (ENGINES)
    ) u_tgt_ram (
        .clk   (clk),
        .we    (tgt_we),
        .waddr (tgt_waddr),
        .wdata (tgt_wdata),
        .raddr (scan_reg),
        .rdata (tgt_rdata)
    );

    mrrt_ram #(
        .WIDTH (RPM_W),
        .DEPTH (ENGINES)
    ) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (scan_reg),
        .wdata (new_rpm),
        .raddr (scan_reg),
        .rdata (cur_rdata)
    );

    mrrt_calc u_calc (
        .cfg      (cfg_reg),
        .present  (cur_rpm),
        .target   (tgt_rpm),
        .code_rpm (p_reg),
        .ramped   (ramped),
        .code     (code)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The scan index does not move between the read in the idle cycle and the
    // update cycle, so the valid bits can be looked up directly here. An
    // entry that was never written stands for the reset value of zero.
    always_comb
    begin
        tgt_word = tgt_vld_reg[scan_reg] ? tgt_rdata : '0;
        tgt_rpm  = tgt_word[RPM_W-1:0];
        tgt_mode = tgt_word[RPM_W];
        cur_rpm  = cur_vld_reg[scan_reg] ? cur_rdata : '0;
        new_rpm  = tgt_mode ? ramped : tgt_rpm;
        // Step mode moves whenever the RPM differs; ramp mode moves only once per tick.
        wr_now   = (cur_rpm != tgt_rpm) && (!tgt_mode || tick_reg[scan_reg]);
        tout_now = (ka_cnt_reg >= cfg_reg.keepalive_limit) && !ka_inh_reg;
    end

    // Fault latch after a service: device fault sets general and device bits,
    // and a service while running clears the not-running bit.
    always_comb
    begin
        svc_fault = fault_reg;
        if (in_data.device_fault)
        begin
            svc_fault[FLT_GENERAL] = 1'b1;
            svc_fault[FLT_DEVICE]  = 1'b1;
        end
        if (run_reg)
        begin
            svc_fault[FLT_NOT_RUNNING] = 1'b0;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_data.action) inside
                        ACT_SET_THROTTLE:
                        begin
                            state_next = (in_data.engine_index == IDX_W'(ENGINES))
                                         ? ST_FILL : ST_EMIT_NONE;
                        end
                        ACT_TICK, ACT_ENABLE_RUN:
                        begin
                            state_next = ST_EMIT_NONE;
                        end
                        ACT_SERVICE:
                        begin
                            state_next = run_reg ? ST_UPDATE : ST_EMIT_NONE;
                        end
                        default:
                        begin
                            state_next = ST_EMIT_NONE;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                if (cnt_reg == LAST_ENG)
                begin
                    state_next = ST_EMIT_NONE;
                end
            end
            ST_UPDATE:
            begin
                if (wr_now)
                begin
                    state_next = ST_EMIT_WR;
                end
                else
                begin
                    state_next = tout_now ? ST_EMIT_ZERO : ST_EMIT_NONE;
                end
            end
            ST_EMIT_WR:
            begin
                if (out_free)
                begin
                    state_next = tout_reg ? ST_EMIT_ZERO : ST_IDLE;
                end
            end
            ST_EMIT_ZERO:
            begin
                if (out_free && (cnt_reg == LAST_ENG))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_NONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and result loads for each state.
    always_comb
    begin
        run_next       = run_reg;
        scan_next      = scan_reg;
        tick_next      = tick_reg;
        ka_cnt_next    = ka_cnt_reg;
        ka_inh_next    = ka_inh_reg;
        fault_next     = fault_reg;
        cfg_next       = cfg_reg;
        tgt_vld_next   = tgt_vld_reg;
        cur_vld_next   = cur_vld_reg;
        cnt_next       = cnt_reg;
        ch_next        = ch_reg;
        tout_next      = tout_reg;
        item_rpm_next  = item_rpm_reg;
        item_mode_next = item_mode_reg;
        p_next         = p_reg;
        tgt_we         = 1'b0;
        tgt_waddr      = in_data.engine_index[ENG_AW-1:0];
        tgt_wdata      = {in_data.ramp_mode, in_data.target_rpm};
        cur_we         = 1'b0;
        out_load       = 1'b0;

        out_load_data.write_valid = 1'b0;
        out_load_data.dac_channel = '0;
        out_load_data.dac_code    = '0;
        out_load_data.fault_flags = fault_reg;
        out_load_data.running     = run_reg;
        out_load_data.last        = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_data.action)
                        ACT_SET_THROTTLE:
                        begin
                            if (in_data.engine_index < IDX_W'(ENGINES))
                            begin
                                tgt_we      = 1'b1;
                                tgt_vld_next[in_data.engine_index[ENG_AW-1:0]] = 1'b1;
                                ka_cnt_next = '0;
                                ka_inh_next = 1'b0;
                            end
                            else if (in_data.engine_index == IDX_W'(ENGINES))
                            begin
                                item_rpm_next  = in_data.target_rpm;
                                item_mode_next = in_data.ramp_mode;
                                cnt_next       = '0;
                                ka_cnt_next    = '0;
                                ka_inh_next    = (in_data.target_rpm == '0);
                            end
                            else
                            begin
                                fault_next[FLT_GENERAL]   = 1'b1;
                                fault_next[FLT_BAD_INDEX] = 1'b1;
                            end
                        end
                        ACT_TICK:
                        begin
                            tick_next = '1;
                            if (ka_cnt_reg != KA_MAX)
                            begin
                                ka_cnt_next = ka_cnt_reg + 1'b1;
                            end
                        end
                        ACT_ENABLE_RUN:
                        begin
                            run_next = 1'b1;
                        end
                        ACT_SERVICE:
                        begin
                            fault_next = svc_fault;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                tgt_we                = 1'b1;
                tgt_waddr             = cnt_reg;
                tgt_wdata             = {item_mode_reg, item_rpm_reg};
                tgt_vld_next[cnt_reg] = 1'b1;
                cnt_next              = cnt_reg + 1'b1;
            end
            ST_UPDATE:
            begin
                if (wr_now)
                begin
                    cur_we                 = 1'b1;
                    cur_vld_next[scan_reg] = 1'b1;
                    p_next                 = new_rpm;
                    if (tgt_mode)
                    begin
                        tick_next[scan_reg] = 1'b0;
                    end
                end
                ch_next   = scan_reg;
                scan_next = (scan_reg == LAST_ENG) ? '0 : scan_reg + 1'b1;
                tout_next = tout_now;
                cnt_next  = '0;
                if (tout_now)
                begin
                    ka_inh_next = 1'b1;
                end
            end
            ST_EMIT_WR:
            begin
                out_load                  = out_free;
                out_load_data.write_valid = 1'b1;
                out_load_data.dac_channel = CH_W'(ch_reg);
                out_load_data.dac_code    = code;
                out_load_data.last        = !tout_reg;
            end
            ST_EMIT_ZERO:
            begin
                out_load                  = out_free;
                out_load_data.write_valid = 1'b1;
                out_load_data.dac_channel = CH_W'(cnt_reg);
                out_load_data.last        = (cnt_reg == LAST_ENG);
                if (out_free)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EMIT_NONE:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RAMP_UP:    cfg_next.ramp_up_step    = cfg_data;
                CFG_RAMP_DOWN:  cfg_next.ramp_down_step  = cfg_data;
                CFG_KA_LIMIT:   cfg_next.keepalive_limit = cfg_data[KA_W-1:0];
                CFG_DAC_GAIN:   cfg_next.dac_gain        = cfg_data[GAIN_W-1:0];
                CFG_DAC_OFFSET: cfg_next.dac_offset      = cfg_data;
                default:
                begin
                end
            endcase
        end

        out_valid_next = out_load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                   <= ST_IDLE;
            run_reg                     <= 1'b0;
            scan_reg                    <= '0;
            tick_reg                    <= '0;
            ka_cnt_reg                  <= '0;
            ka_inh_reg                  <= 1'b1;
            fault_reg                   <= FAULT_RESET;
            cfg_reg.ramp_up_step        <= RST_RAMP_UP;
            cfg_reg.ramp_down_step      <= RST_RAMP_DOWN;
            cfg_reg.keepalive_limit     <= RST_KA_LIMIT;
            cfg_reg.dac_gain            <= RST_DAC_GAIN;
            cfg_reg.dac_offset          <= RST_DAC_OFFSET;
            tgt_vld_reg                 <= '0;
            cur_vld_reg                 <= '0;
            cnt_reg                     <= '0;
            ch_reg                      <= '0;
            tout_reg                    <= 1'b0;
            out_valid_reg               <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            scan_reg      <= scan_next;
            tick_reg      <= tick_next;
            ka_cnt_reg    <= ka_cnt_next;
            ka_inh_reg    <= ka_inh_next;
            fault_reg     <= fault_next;
            cfg_reg       <= cfg_next;
            tgt_vld_reg   <= tgt_vld_next;
            cur_vld_reg   <= cur_vld_next;
            cnt_reg       <= cnt_next;
            ch_reg        <= ch_next;
            tout_reg      <= tout_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_rpm_reg  <= item_rpm_next;
        item_mode_reg <= item_mode_next;
        p_reg         <= p_next;
        if (out_load)
        begin
            out_data_reg <= out_load_data;
        end
    end

    // One item at a time: a transfer on the input always leaves idle.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted twice in a row");

    // DAC writes only come from a running block, which has cleared not-running.
    a_write_running: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.write_valid |->
            out_data.running && !out_data.fault_flags[FLT_NOT_RUNNING])
        else $error("DAC write without run mode");

    // The zeroing sweep runs only after the watchdog has been inhibited.
    a_sweep_inhibited: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT_ZERO |-> ka_inh_reg && tout_reg)
        else $error("zeroing sweep without watchdog inhibit");

endmodule
